[rtl/collision_velocity_reflect_top_defines.svh]
// Assertion macros shared by the checker of the collision velocity reflection block.
`ifndef COLLISION_VELOCITY_REFLECT_TOP_DEFINES_SVH
`define COLLISION_VELOCITY_REFLECT_TOP_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define CVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
// Assert that a condition always holds.
`define CVR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("assertion failed");
`endif

[rtl/cvr_pkg.sv]
// Package of the collision velocity reflection block: beat types and constants.
package cvr_pkg;
	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic [16:0] restitution;
		logic [16:0] friction;
	} cvr_in_t;

	typedef struct packed {
		logic signed [31:0] out_vel_x;
		logic signed [31:0] out_vel_y;
		logic reflected;
	} cvr_out_t;

	localparam logic signed [35:0] TAN_LIMIT = 36'sd3037000499;
endpackage

[rtl/collision_velocity_reflect_top.sv]
// Top level of the collision velocity reflection block.
//
// One input beat is taken on each clock edge where start is high and busy is
// low; busy is tied low, so a beat may enter in every cycle. The result beat is
// loaded into the output register after the last divider stage and sits on result,
// with done high, for exactly the following cycle; beats leave in order.
// The pipeline holds these stages in order: five stages for the dot product,
// the normal parts, the reflection and tangent, and the squares, 32 stages of a
// pipelined square root (one result bit per stage), one stage that limits the
// drop, 48 stages of a pipelined restoring divider (two quotients of 48 bits,
// one bit per stage, run side by side) and the output register.
// Throughput is one beat per cycle.
// The receiver cannot stall, so the pipeline never stops; valid bits travel
// beside the data and are cleared by reset. Payload registers are not reset.
module collision_velocity_reflect_top
	import cvr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cvr_in_t  item,
	output logic     done,
	output cvr_out_t result
);
	localparam int SQ = 32;
	localparam int DV = 48;

	assign busy = 1'b0;
	wire take = start & ~busy;

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
		logic [63:0] m;
		logic [63:0] r;
		begin
			m = v[63] ? 64'(-v) : 64'(v);
			r = (m + (64'd1 << (s - 1))) >> s;
			rnd = v[63] ? -$signed(r) : $signed(r);
		end
	endfunction

	// Stage 1: products of the dot product.
	logic v_s1;
	cvr_in_t d_s1;
	logic signed [47:0] px_s1, py_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= take;
	end
	always_ff @(posedge clk) begin
		d_s1 <= item;
		px_s1 <= 48'(item.vel_x * item.normal_x);
		py_s1 <= 48'(item.vel_y * item.normal_y);
	end

	// Stage 2: dot product and rounded normal speed.
	logic v_s2, neg_s2;
	cvr_in_t d_s2;
	logic signed [35:0] vn_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		logic signed [48:0] dn;
		dn = 49'(px_s1) + 49'(py_s1);
		d_s2 <= d_s1;
		neg_s2 <= dn[48];
		vn_s2 <= 36'(rnd(64'(dn), 14));
	end

	// Stage 3: normal components.
	logic v_s3, neg_s3;
	cvr_in_t d_s3;
	logic signed [35:0] vn_s3, pnx_s3, pny_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		d_s3 <= d_s2;
		neg_s3 <= neg_s2;
		vn_s3 <= vn_s2;
		pnx_s3 <= 36'(rnd(64'(d_s2.normal_x * vn_s2), 14));
		pny_s3 <= 36'(rnd(64'(d_s2.normal_y * vn_s2), 14));
	end

	// Stage 4: reflection, clamped tangent, friction drop.
	logic v_s4, neg_s4;
	logic signed [36:0] rx_s4, ry_s4;
	logic signed [35:0] tx_s4, ty_s4;
	logic [35:0] drop_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		logic signed [36:0] tx, ty;
		logic [35:0] avn;
		logic signed [18:0] k;
		tx = 37'(d_s3.vel_x) - 37'(pnx_s3);
		ty = 37'(d_s3.vel_y) - 37'(pny_s3);
		avn = vn_s3[35] ? 36'(-vn_s3) : 36'(vn_s3);
		k = 19'sd65536 + $signed({2'b0, d_s3.restitution});
		neg_s4 <= neg_s3;
		rx_s4 <= 37'(d_s3.vel_x) - 37'(rnd(64'(pnx_s3 * k), 16));
		ry_s4 <= 37'(d_s3.vel_y) - 37'(rnd(64'(pny_s3 * k), 16));
		tx_s4 <= tx > 37'(TAN_LIMIT) ? TAN_LIMIT : (tx < -37'(TAN_LIMIT) ? -TAN_LIMIT : 36'(tx));
		ty_s4 <= ty > 37'(TAN_LIMIT) ? TAN_LIMIT : (ty < -37'(TAN_LIMIT) ? -TAN_LIMIT : 36'(ty));
		drop_s4 <= 36'(rnd($signed(64'({1'b0, d_s3.friction} * avn)), 16));
	end

	// Stage 5: squares.
	logic v_s5, neg_s5;
	logic signed [36:0] rx_s5, ry_s5;
	logic signed [35:0] tx_s5, ty_s5;
	logic [35:0] drop_s5;
	logic [63:0] sq_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		neg_s5 <= neg_s4; rx_s5 <= rx_s4; ry_s5 <= ry_s4;
		tx_s5 <= tx_s4; ty_s5 <= ty_s4; drop_s5 <= drop_s4;
		sq_s5 <= 64'(tx_s4 * tx_s4) + 64'(ty_s4 * ty_s4);
	end

	// Pipelined square root, one result bit per stage.
	typedef struct packed {
		logic neg;
		logic signed [36:0] rx, ry;
		logic signed [35:0] tx, ty;
		logic [35:0] drop;
		logic [65:0] rem;
		logic [31:0] root;
		logic [63:0] x;
	} sq_t;

	function automatic sq_t sq_step(input sq_t a);
		sq_t b;
		logic [65:0] r;
		logic [65:0] trial;
		b = a;
		r = {a.rem[63:0], a.x[63:62]};
		trial = {32'b0, a.root, 2'b01};
		b.x = {a.x[61:0], 2'b00};
		if (r >= trial) begin
			b.rem = r - trial;
			b.root = {a.root[30:0], 1'b1};
		end else begin
			b.rem = r;
			b.root = {a.root[30:0], 1'b0};
		end
		return b;
	endfunction

	sq_t sq_in;
	sq_t sq_p [1:SQ];
	logic [SQ:1] sq_v;
	always_comb begin
		sq_in = '0;
		sq_in.neg = neg_s5; sq_in.rx = rx_s5; sq_in.ry = ry_s5;
		sq_in.tx = tx_s5; sq_in.ty = ty_s5; sq_in.drop = drop_s5; sq_in.x = sq_s5;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v <= '0;
		else sq_v <= {sq_v[SQ-1:1], v_s5};
	end
	always_ff @(posedge clk) begin
		sq_p[1] <= sq_step(sq_in);
		for (int i = 2; i <= SQ; i++) begin
			sq_p[i] <= sq_step(sq_p[i-1]);
		end
	end

	// Stage: limit the drop and form rounded dividends.
	logic v_d0, neg_d0, skip_d0, sx_d0, sy_d0;
	logic signed [36:0] rx_d0, ry_d0;
	logic [31:0] ts_d0;
	logic [71:0] nx_d0, ny_d0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d0 <= 1'b0;
		else v_d0 <= sq_v[SQ];
	end
	always_ff @(posedge clk) begin
		logic [35:0] dr;
		logic [35:0] ax, ay;
		dr = sq_p[SQ].drop > 36'(sq_p[SQ].root) ? 36'(sq_p[SQ].root) : sq_p[SQ].drop;
		ax = sq_p[SQ].tx[35] ? 36'(-sq_p[SQ].tx) : 36'(sq_p[SQ].tx);
		ay = sq_p[SQ].ty[35] ? 36'(-sq_p[SQ].ty) : 36'(sq_p[SQ].ty);
		neg_d0 <= sq_p[SQ].neg; rx_d0 <= sq_p[SQ].rx; ry_d0 <= sq_p[SQ].ry;
		ts_d0 <= sq_p[SQ].root;
		skip_d0 <= (sq_p[SQ].root == 32'd0);
		sx_d0 <= sq_p[SQ].tx[35]; sy_d0 <= sq_p[SQ].ty[35];
		nx_d0 <= 72'(ax * dr) + 72'(sq_p[SQ].root >> 1);
		ny_d0 <= 72'(ay * dr) + 72'(sq_p[SQ].root >> 1);
	end

	// Pipelined restoring divider; the quotient fits in 48 bits since drop <= ts.
	typedef struct packed {
		logic neg, skip, sx, sy;
		logic signed [36:0] rx, ry;
		logic [31:0] ts;
		logic [71:0] ax, ay;
		logic [47:0] qx, qy;
		logic [32:0] remx, remy;
	} dv_t;

	function automatic dv_t dv_step(input dv_t a);
		dv_t b;
		logic [32:0] r1, r2;
		b = a;
		r1 = {a.remx[31:0], a.ax[71]};
		r2 = {a.remy[31:0], a.ay[71]};
		b.ax = {a.ax[70:0], 1'b0};
		b.ay = {a.ay[70:0], 1'b0};
		if (r1 >= {1'b0, a.ts}) begin
			b.remx = r1 - {1'b0, a.ts};
			b.qx = {a.qx[46:0], 1'b1};
		end else begin
			b.remx = r1;
			b.qx = {a.qx[46:0], 1'b0};
		end
		if (r2 >= {1'b0, a.ts}) begin
			b.remy = r2 - {1'b0, a.ts};
			b.qy = {a.qy[46:0], 1'b1};
		end else begin
			b.remy = r2;
			b.qy = {a.qy[46:0], 1'b0};
		end
		return b;
	endfunction

	dv_t dv_in;
	dv_t dv_p [1:DV];
	logic [DV:1] dv_v;
	always_comb begin
		dv_in = '0;
		dv_in.neg = neg_d0; dv_in.skip = skip_d0;
		dv_in.sx = sx_d0; dv_in.sy = sy_d0; dv_in.rx = rx_d0; dv_in.ry = ry_d0;
		dv_in.ts = ts_d0; dv_in.ax = nx_d0 << 24; dv_in.ay = ny_d0 << 24;
		dv_in.remx = 33'(nx_d0 >> 48); dv_in.remy = 33'(ny_d0 >> 48);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v <= '0;
		else dv_v <= {dv_v[DV-1:1], v_d0};
	end
	always_ff @(posedge clk) begin
		dv_p[1] <= dv_step(dv_in);
		for (int j = 2; j <= DV; j++) begin
			dv_p[j] <= dv_step(dv_p[j-1]);
		end
	end

	// Final stage: apply friction, select pass-through, saturate.
	logic signed [31:0] vx_p [SQ+DV+6];
	logic signed [31:0] vy_p [SQ+DV+6];
	always_ff @(posedge clk) begin
		vx_p[0] <= item.vel_x;
		vy_p[0] <= item.vel_y;
		for (int k = 0; k < SQ + DV + 5; k++) begin
			vx_p[k+1] <= vx_p[k];
			vy_p[k+1] <= vy_p[k];
		end
	end

	function automatic logic signed [31:0] sat(input logic signed [49:0] v);
		if (v > 50'sd2147483647) sat = 32'sh7fffffff;
		else if (v < -50'sd2147483648) sat = 32'sh80000000;
		else sat = 32'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= dv_v[DV];
	end
	always_ff @(posedge clk) begin
		logic signed [49:0] fx, fy;
		fx = dv_p[DV].skip ? 50'sd0 :
			(dv_p[DV].sx ? -$signed({2'b0, dv_p[DV].qx}) : $signed({2'b0, dv_p[DV].qx}));
		fy = dv_p[DV].skip ? 50'sd0 :
			(dv_p[DV].sy ? -$signed({2'b0, dv_p[DV].qy}) : $signed({2'b0, dv_p[DV].qy}));
		if (dv_p[DV].neg) begin
			result.out_vel_x <= sat(50'(dv_p[DV].rx) - fx);
			result.out_vel_y <= sat(50'(dv_p[DV].ry) - fy);
		end else begin
			result.out_vel_x <= vx_p[SQ+DV+5];
			result.out_vel_y <= vy_p[SQ+DV+5];
		end
		result.reflected <= dv_p[DV].neg;
	end
endmodule

[rtl/cvr_checker.sv]
// Port checker of the collision velocity reflection block, with its bind.
`include "collision_velocity_reflect_top_defines.svh"
module cvr_checker
	import cvr_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input cvr_out_t result
);
	// Edges from the one that takes a beat to the first one that samples its done.
	localparam int LAT = 87;

	`CVR_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	`CVR_ASSERT_NEXT(a_latency, clk, arst_n, $past(start && !busy, LAT - 1), done)
	`CVR_ASSERT_ALWAYS(a_no_stray, clk, arst_n, !done || $past(start && !busy, LAT))
	`CVR_ASSERT_ALWAYS(a_result_known, clk, arst_n, !done || !$isunknown(result))
endmodule

bind collision_velocity_reflect_top cvr_checker u_cvr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);

[verif/tb.sv]
// Testbench of the collision velocity reflection block: scoreboard, stimulus and checking.
`timescale 1ns / 1ps

class cvr_scoreboard;
	cvr_pkg::cvr_out_t pending_q[$];
	int errors;

	static function longint round_shift(longint v, int s);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (s - 1))) >>> s;
		return (v < 0) ? -mag : mag;
	endfunction

	static function longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	static function longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	static function longint steer(longint t, longint unsigned red, longint unsigned ts);
		longint unsigned q, mag;
		mag = (t < 0) ? -t : t;
		q = (mag * red + ts / 2) / ts;
		return (t < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Works out the bounced velocity for one contact.
	static function cvr_pkg::cvr_out_t bounce(cvr_pkg::cvr_in_t c);
		cvr_pkg::cvr_out_t r;
		longint vx, vy, nx, ny, e, f, rx, ry, dn, vn, pnx, pny, tx, ty, lim;
		longint unsigned ts, drop;
		vx = longint'(c.vel_x); vy = longint'(c.vel_y);
		nx = longint'(c.normal_x); ny = longint'(c.normal_y);
		e = longint'(c.restitution); f = longint'(c.friction);
		lim = 64'sd3037000499;
		rx = vx; ry = vy;
		r.reflected = 1'b0;
		dn = vx * nx + vy * ny;
		if (dn < 0) begin
			vn = round_shift(dn, 14);
			pnx = round_shift(nx * vn, 14);
			pny = round_shift(ny * vn, 14);
			r.reflected = 1'b1;
			rx = vx - round_shift(pnx * (65536 + e), 16);
			ry = vy - round_shift(pny * (65536 + e), 16);
			tx = clamp(vx - pnx, -lim, lim);
			ty = clamp(vy - pny, -lim, lim);
			ts = int_sqrt(longint'(tx * tx) + longint'(ty * ty));
			if (ts != 0) begin
				drop = round_shift(f * ((vn < 0) ? -vn : vn), 16);
				if (drop > ts) drop = ts;
				rx -= steer(tx, drop, ts);
				ry -= steer(ty, drop, ts);
			end
		end
		r.out_vel_x = 32'(clamp(rx, -64'sd2147483648, 64'sd2147483647));
		r.out_vel_y = 32'(clamp(ry, -64'sd2147483648, 64'sd2147483647));
		return r;
	endfunction

	function void note_contact(cvr_pkg::cvr_in_t c);
		pending_q.push_back(bounce(c));
	endfunction

	function void report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endfunction

	function void check_result(cvr_pkg::cvr_out_t r);
		cvr_pkg::cvr_out_t x;
		if (pending_q.size() == 0) begin
			report("result beat with nothing expected");
			return;
		end
		x = pending_q.pop_front();
		if (r.out_vel_x !== x.out_vel_x)
			report($sformatf("out_vel_x got %0d want %0d", r.out_vel_x, x.out_vel_x));
		if (r.out_vel_y !== x.out_vel_y)
			report($sformatf("out_vel_y got %0d want %0d", r.out_vel_y, x.out_vel_y));
		if (r.reflected !== x.reflected)
			report($sformatf("reflected got %0b want %0b", r.reflected, x.reflected));
	endfunction
endclass

module tb;
	import cvr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	cvr_in_t item = '0;
	cvr_out_t result;

	cvr_scoreboard sb = new();
	longint cycles = 0;
	bit idle_ok = 1'b1;

	// The limit covers every beat waiting out the longest gap and the pipeline
	// depth, many times over.
	localparam longint LIMIT = 200000;

	collision_velocity_reflect_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Results are taken at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) sb.check_result(result);
		if (cycles > LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Drives one beat and holds it until the block takes it.
	task automatic send(cvr_in_t c);
		item <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_contact(c);
		if (idle_ok && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_normal();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd11585;
			3: return -16'sd11585;
			4: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic cvr_in_t rand_contact();
		cvr_in_t c;
		c.vel_x = $urandom;
		c.vel_y = $urandom;
		if ($urandom_range(0, 2) == 0) begin
			c.vel_x = $signed(c.vel_x) >>> $urandom_range(0, 30);
			c.vel_y = $signed(c.vel_y) >>> $urandom_range(0, 30);
		end
		c.normal_x = pick_normal();
		c.normal_y = pick_normal();
		c.restitution = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
		c.friction = 17'($urandom);
		return c;
	endfunction

	function automatic cvr_in_t mk(int vx, int vy, int nx, int ny, int e, int f);
		cvr_in_t c;
		c.vel_x = vx; c.vel_y = vy; c.normal_x = 16'(nx); c.normal_y = 16'(ny);
		c.restitution = 17'(e); c.friction = 17'(f);
		return c;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: passing through, grazing, zero tangent, large tangent, saturation.
		send(mk(65536, 65536, 0, 16384, 32768, 65536));
		send(mk(0, 0, 16384, 0, 65536, 131071));
		send(mk(0, -65536, 0, 16384, 65536, 0));
		send(mk(0, -65536, 0, 16384, 0, 131071));
		send(mk(-1, 0, 1, 0, 65536, 65536));
		send(mk(32'h7fffffff, 32'h80000000, 0, 16384, 65536, 131071));
		send(mk(32'h80000000, 32'h80000000, 16384, 16384, 131071, 131071));
		send(mk(32'h7fffffff, 32'h7fffffff, -16384, -16384, 65536, 0));
		send(mk(32'h80000000, 32'h7fffffff, 16'h7fff, 16'h8000, 131071, 131071));
		send(mk(100000, -200000, 11585, 11585, 0, 0));
		send(mk(32'h40000000, -5, 0, 16384, 65536, 131071));
		send(mk(-3, 7, 16384, -16384, 1, 1));
		// Pause until everything sent so far has come back.
		drain();
		repeat (380) begin
			if (sb.pending_q.size() == 0 && $urandom_range(0, 40) == 0) idle_ok = 1'b1;
			send(rand_contact());
		end
		idle_ok = 1'b0;
		repeat (60) send(rand_contact());
		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/cvr_pkg.sv
rtl/collision_velocity_reflect_top.sv
rtl/cvr_checker.sv
verif/tb.sv
